// ===== src/sprite_span_stream_decoder_core_macros.svh =====
// assertion macros used by the sprite span decoder top level
`ifndef SPRITE_SPAN_STREAM_DECODER_CORE_MACROS_SVH
`define SPRITE_SPAN_STREAM_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define SSSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define SSSD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sssd_pkg.sv =====
// shared types and constants of the sprite span decoder
package sssd_pkg;

    localparam int DEF_SCREEN_PITCH = 304;
    localparam int DEF_NUM_COLORS   = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_MIRRORED = 2'd2;

    // stream control bytes
    localparam logic [7:0] CTRL_NEW_OFFSET = 8'h99;
    localparam logic [7:0] CTRL_END_COLOR  = 8'haa;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic               mirrored;
    } sssd_cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } sssd_item_t;

    typedef struct packed {
        logic [9:0]         span_length;
        logic signed [15:0] span_x;
        logic signed [15:0] span_y;
        logic [3:0]         span_color;
        logic               right_to_left;
        logic               sprite_done;
    } sssd_result_t;

endpackage

// ===== src/sssd_apb_regs.sv =====
// apb configuration registers: origin and mirror mode
module sssd_apb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sssd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sssd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sssd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output sssd_pkg::sssd_cfg_t                cfg
);

    sssd_pkg::sssd_cfg_t cfg_reg;
    logic                wr_en;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                sssd_pkg::REG_ORIGIN_X: cfg_reg.origin_x <= pwdata[15:0];
                sssd_pkg::REG_ORIGIN_Y: cfg_reg.origin_y <= pwdata[15:0];
                sssd_pkg::REG_MIRRORED: cfg_reg.mirrored <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sssd_pkg::REG_ORIGIN_X: prdata = {16'h0000, cfg_reg.origin_x};
            sssd_pkg::REG_ORIGIN_Y: prdata = {16'h0000, cfg_reg.origin_y};
            sssd_pkg::REG_MIRRORED: prdata = {31'd0, cfg_reg.mirrored};
            default:                prdata = '0;
        endcase
    end

endmodule

// ===== src/sssd_in_stage.sv =====
// input register for the byte stream
module sssd_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic                take,
    output logic                item_valid,
    output sssd_pkg::sssd_item_t item
);

    logic                 valid_reg;
    sssd_pkg::sssd_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            item_reg.data_byte  <= s_tdata;
            item_reg.first_byte <= s_tuser[0];
        end
    end

endmodule

// ===== src/sssd_parser.sv =====
// span stream parse step with result register
module sssd_parser #(
    parameter int SCREEN_PITCH = sssd_pkg::DEF_SCREEN_PITCH,
    parameter int NUM_COLORS   = sssd_pkg::DEF_NUM_COLORS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  sssd_pkg::sssd_item_t   item,
    output logic                   take,
    input  sssd_pkg::sssd_cfg_t    cfg,
    input  logic                   m_ready,
    output logic                   out_valid,
    output sssd_pkg::sssd_result_t result
);

    localparam int CW          = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
    localparam int RECIP_SHIFT = 16 + $clog2(SCREEN_PITCH);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(SCREEN_PITCH) - 64'd1) / 64'(SCREEN_PITCH);
    localparam logic [16:0] RECIP = 17'(RECIP_FULL);

    typedef enum logic [2:0] {
        PH_MASK_HI = 3'd0,
        PH_MASK_LO = 3'd1,
        PH_OFF_HI  = 3'd2,
        PH_OFF_LO  = 3'd3,
        PH_LEN     = 3'd4,
        PH_CTRL    = 3'd5
    } phase_t;

    function automatic logic [CW:0] lowest_set(input logic [NUM_COLORS-1:0] v);
        logic [CW:0] r;
        r = '0;
        for (int i = NUM_COLORS - 1; i >= 0; i--) begin
            if (v[i]) r = {1'b1, CW'(i)};
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767)       r = 16'sh7fff;
        else if (v < -17'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [16:0] clamp17(input logic signed [17:0] v);
        logic signed [16:0] r;
        if (v > 18'sd65535)       r = 17'sh0ffff;
        else if (v < -18'sd65536) r = 17'sh10000;
        else                      r = v[16:0];
        return r;
    endfunction

    phase_t                 phase_reg, phase_next, eff_phase;
    logic [NUM_COLORS-1:0]  colors_left_reg, colors_left_next;
    logic [CW-1:0]          color_reg, color_next;
    logic [7:0]             offset_high_reg, offset_high_next;
    logic signed [10:0]     run_reg, run_next;
    logic signed [16:0]     pen_x_reg, pen_x_next;
    logic signed [16:0]     pen_y_reg, pen_y_next;
    logic [15:0]            off_reg, off_next;
    logic [15:0]            quot_reg, quot_next;
    logic                   mir_snap_reg, mir_snap_next;
    logic                   out_valid_reg;
    sssd_pkg::sssd_result_t result_reg, result_next;
    logic                   emit;

    logic [7:0]             b;
    logic [15:0]            hi16, merged16, offset;
    logic [NUM_COLORS-1:0]  merged_mask, cleared_mask, pick_src;
    logic [CW:0]            pick;
    logic [32:0]            prod;
    logic [31:0]            qp;
    logic [15:0]            rem;
    logic signed [12:0]     run_sum;
    logic signed [3:0]      nib_lo, nib_hi;
    logic signed [17:0]     y_inc, x_step;

    assign take      = item_valid && (!out_valid_reg || m_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign b            = item.data_byte;
    assign eff_phase    = item.first_byte ? PH_MASK_HI : phase_reg;
    assign hi16         = {b, 8'h00};
    assign merged16     = 16'(colors_left_reg) | {8'h00, b};
    assign merged_mask  = merged16[NUM_COLORS-1:0];
    assign cleared_mask = colors_left_reg & ~(NUM_COLORS'(1) << color_reg);
    assign pick_src     = (eff_phase == PH_MASK_LO) ? merged_mask : cleared_mask;
    assign pick         = lowest_set(pick_src);

    // quotient by the pitch through an exact reciprocal
    assign offset = {offset_high_reg, b};
    assign prod   = 33'(offset) * 33'(RECIP);
    // remainder from the quotient latched on the previous byte
    assign qp     = 32'(quot_reg) * 32'(SCREEN_PITCH);
    assign rem    = off_reg - qp[15:0];

    assign nib_lo  = b[3:0];
    assign nib_hi  = b[7:4];
    assign run_sum = 13'(run_reg) + 13'(nib_lo) - 13'(nib_hi);
    assign y_inc   = 18'(pen_y_reg) + 18'sd1;
    assign x_step  = cfg.mirrored ? 18'(pen_x_reg) - 18'(nib_hi)
                                  : 18'(pen_x_reg) + 18'(nib_hi);

    always_comb begin
        phase_next       = phase_reg;
        colors_left_next = colors_left_reg;
        color_next       = color_reg;
        offset_high_next = offset_high_reg;
        run_next         = run_reg;
        pen_x_next       = pen_x_reg;
        pen_y_next       = pen_y_reg;
        off_next         = off_reg;
        quot_next        = quot_reg;
        mir_snap_next    = mir_snap_reg;
        emit             = 1'b0;
        result_next      = '0;

        unique case (eff_phase)
            PH_MASK_HI: begin
                colors_left_next = hi16[NUM_COLORS-1:0];
                phase_next       = PH_MASK_LO;
            end
            PH_MASK_LO: begin
                if (pick[CW]) begin
                    colors_left_next = merged_mask;
                    color_next       = pick[CW-1:0];
                    phase_next       = PH_OFF_HI;
                end else begin
                    colors_left_next        = '0;
                    phase_next              = PH_MASK_HI;
                    emit                    = 1'b1;
                    result_next.sprite_done = 1'b1;
                end
            end
            PH_OFF_HI: begin
                offset_high_next = b;
                phase_next       = PH_OFF_LO;
            end
            PH_OFF_LO: begin
                off_next      = offset;
                quot_next     = 16'(prod >> RECIP_SHIFT);
                pen_x_next    = 17'(cfg.origin_x);
                pen_y_next    = 17'(cfg.origin_y);
                mir_snap_next = cfg.mirrored;
                phase_next    = PH_LEN;
            end
            PH_LEN: begin
                run_next   = 11'({3'b000, b}) + 11'sd1;
                pen_x_next = mir_snap_reg ? pen_x_reg - $signed({1'b0, rem})
                                          : pen_x_reg + $signed({1'b0, rem});
                pen_y_next = pen_y_reg + $signed({1'b0, quot_reg});
                phase_next = PH_CTRL;
                emit       = 1'b1;
            end
            PH_CTRL: begin
                priority if (b == sssd_pkg::CTRL_NEW_OFFSET) begin
                    phase_next = PH_OFF_HI;
                end else if (b == sssd_pkg::CTRL_END_COLOR) begin
                    if (pick[CW]) begin
                        colors_left_next = cleared_mask;
                        color_next       = pick[CW-1:0];
                        phase_next       = PH_OFF_HI;
                    end else begin
                        colors_left_next        = '0;
                        phase_next              = PH_MASK_HI;
                        emit                    = 1'b1;
                        result_next.sprite_done = 1'b1;
                    end
                end else begin
                    if (run_sum > 13'sd1023)       run_next = 11'sd1023;
                    else if (run_sum < -13'sd1024) run_next = -11'sd1024;
                    else                           run_next = run_sum[10:0];
                    pen_y_next = clamp17(y_inc);
                    pen_x_next = clamp17(x_step);
                    emit       = 1'b1;
                end
            end
            default: begin
                phase_next = PH_MASK_HI;
            end
        endcase

        if (emit && !result_next.sprite_done) begin
            result_next.span_length   = run_next[10] ? 10'd0 : run_next[9:0];
            result_next.span_x        = sat16(pen_x_next);
            result_next.span_y        = sat16(pen_y_next);
            result_next.span_color    = 4'(color_next);
            result_next.right_to_left = cfg.mirrored;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_MASK_HI;
            colors_left_reg <= '0;
            color_reg       <= '0;
            offset_high_reg <= '0;
            run_reg         <= '0;
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (take) begin
                phase_reg       <= phase_next;
                colors_left_reg <= colors_left_next;
                color_reg       <= color_next;
                offset_high_reg <= offset_high_next;
                run_reg         <= run_next;
                pen_x_reg       <= pen_x_next;
                pen_y_reg       <= pen_y_next;
                out_valid_reg   <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (take) begin
            off_reg      <= off_next;
            quot_reg     <= quot_next;
            mir_snap_reg <= mir_snap_next;
            if (emit) result_reg <= result_next;
        end
    end

endmodule

// ===== src/sprite_span_stream_decoder_core.sv =====
// top level of the sprite span stream decoder
// Takes a sprite frame's span stream one byte per transfer and gives one span or done
// result per byte that causes one. It accepts a byte in every cycle as long as the result
// side keeps up; a result passes through the input register, then the result register.
// While a result is stalled, the byte behind it waits in the input register, and s_tready
// stays low until that result is taken, even if the waiting byte gives no result. The
// offset is split by the screen pitch through a reciprocal multiply on the offset low
// byte, and the remainder is formed on the length byte that follows. Valid and state
// registers reset to zero, data registers are not reset; origin and mirror mode are written
// over apb, and the user must do so only while the stream is quiet: the block does not
// enforce it. There is no clearing pass after reset.
module sprite_span_stream_decoder_core #(
    parameter int SCREEN_PITCH = sssd_pkg::DEF_SCREEN_PITCH,
    parameter int NUM_COLORS   = sssd_pkg::DEF_NUM_COLORS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic [0:0]                      s_tuser,   // [0] first_byte
    // spans out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] span_length, [25:10] span_x, [41:26] span_y, [45:42] span_color, rest zero
    output logic [47:0]                     m_tdata,
    output logic [1:0]                      m_tuser,   // [0] right_to_left, [1] sprite_done
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sssd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sssd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sssd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    sssd_pkg::sssd_cfg_t    cfg;
    sssd_pkg::sssd_item_t   item;
    sssd_pkg::sssd_result_t result;
    logic                   item_valid;
    logic                   take;

    sssd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sssd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sssd_parser #(
        .SCREEN_PITCH (SCREEN_PITCH),
        .NUM_COLORS   (NUM_COLORS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .cfg        (cfg),
        .m_ready    (m_tready),
        .out_valid  (m_tvalid),
        .result     (result)
    );

    assign m_tdata = {2'b00, result.span_color, result.span_y, result.span_x,
                      result.span_length};
    assign m_tuser = {result.sprite_done, result.right_to_left};

`include "sprite_span_stream_decoder_core_macros.svh"

    // a done result carries no span
    `SSSD_ASSERT_IMP(a_done_clean, m_tvalid && m_tuser[1], m_tdata == '0 && !m_tuser[0], "done with data")
    // input side only stalls behind a held result
    `SSSD_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid && !m_tready, "stall without backpressure")
    // a pending byte stays put until the parser takes it
    `SSSD_ASSERT_NXT(a_item_hold, item_valid && !take, item_valid && $stable(item), "pending byte changed")

endmodule

// ===== tb/sprite_span_stream_decoder_core_tb.sv =====
// self-checking testbench of the sprite span stream decoder: directed table, then random sprites
`timescale 1ns / 100ps

module sprite_span_stream_decoder_core_tb;

    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BYTES = 1150;

    typedef enum logic [2:0] {
        PH_MASK_HI,
        PH_MASK_LO,
        PH_OFF_HI,
        PH_OFF_LO,
        PH_LEN,
        PH_CTRL
    } dec_phase_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_TOGGLE
    } rx_mode_t;

    typedef struct packed {
        sssd_pkg::sssd_item_t   item;
        logic                   typed;
        sssd_pkg::sssd_result_t want;
    } stim_row_t;

    localparam sssd_pkg::sssd_result_t DONE_RESULT =
        '{10'd0, 16'sd0, 16'sd0, 4'd0, 1'b0, 1'b1};

    // origin at zero, not mirrored
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{'{8'h00, 1'b0}, 1'b0, '0},  // taken as mask high byte straight after reset
        '{'{8'h00, 1'b0}, 1'b1, DONE_RESULT},  // empty mask
        '{'{8'h80, 1'b0}, 1'b0, '0},  // idle again after done
        '{'{8'h01, 1'b0}, 1'b0, '0},  // colors 0 and 15
        '{'{8'hff, 1'b0}, 1'b0, '0},
        '{'{8'hff, 1'b0}, 1'b0, '0},  // offset 65535 = 215 * 304 + 175
        '{'{8'hff, 1'b0}, 1'b1, '{10'd256, 16'sd175, 16'sd215, 4'd0, 1'b0, 1'b0}},
        '{'{8'h77, 1'b0}, 1'b0, '0},
        '{'{8'h88, 1'b0}, 1'b0, '0},
        '{'{8'h0f, 1'b0}, 1'b0, '0},
        '{'{8'hf0, 1'b0}, 1'b0, '0},
        '{'{sssd_pkg::CTRL_NEW_OFFSET, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0}, 1'b1, '{10'd1, 16'sd0, 16'sd0, 4'd0, 1'b0, 1'b0}},
        '{'{sssd_pkg::CTRL_END_COLOR, 1'b0}, 1'b0, '0},
        '{'{8'h01, 1'b0}, 1'b0, '0},
        '{'{8'h30, 1'b0}, 1'b0, '0},  // offset one pitch: one row down
        '{'{8'h10, 1'b0}, 1'b1, '{10'd17, 16'sd0, 16'sd1, 4'd15, 1'b0, 1'b0}},
        '{'{sssd_pkg::CTRL_END_COLOR, 1'b0}, 1'b1, DONE_RESULT},
        '{'{8'h12, 1'b1}, 1'b0, '0},
        '{'{8'h34, 1'b0}, 1'b0, '0},
        '{'{8'h56, 1'b0}, 1'b0, '0},
        '{'{8'h78, 1'b1}, 1'b0, '0},  // new sprite mark in the middle of an offset
        '{'{8'h00, 1'b0}, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
    logic [0:0]  s_tuser  = '0;   // [0] first_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [9:0] span_length, [25:10] span_x, [41:26] span_y, [45:42] span_color
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;         // [0] right_to_left, [1] sprite_done
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [sssd_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [sssd_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [sssd_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    sprite_span_stream_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // decoder state as the stream should leave it
    dec_phase_t         dec_phase   = PH_MASK_HI;
    logic [15:0]        colors_left = '0;
    logic [3:0]         cur_color   = '0;
    logic [7:0]         off_hi      = '0;
    int                 run_len     = 0;
    int                 pen_x       = 0;
    int                 pen_y       = 0;
    logic signed [15:0] org_x       = '0;
    logic signed [15:0] org_y       = '0;
    logic               mirror      = 1'b0;

    sssd_pkg::sssd_result_t span_expect_q [$];
    stim_row_t              stim_q [$];
    int                     mismatch_count = 0;

    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("** sprite_span_stream_decoder_core: FAILED **");
        $finish;
    end

    function automatic int sat(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit pick_color();
        for (int c = 0; c < sssd_pkg::DEF_NUM_COLORS; c++) begin
            if (colors_left[c]) begin
                cur_color = 4'(c);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic sssd_pkg::sssd_result_t span_at_pen();
        sssd_pkg::sssd_result_t r;
        r.span_length   = 10'(sat(run_len, 0, 1023));
        r.span_x        = 16'(sat(pen_x, -32768, 32767));
        r.span_y        = 16'(sat(pen_y, -32768, 32767));
        r.span_color    = cur_color;
        r.right_to_left = mirror;
        r.sprite_done   = 1'b0;
        return r;
    endfunction

    // advances the decoder by one stream byte; returns 1 when the byte yields a result
    function automatic bit decode_byte(input sssd_pkg::sssd_item_t it,
                                       output sssd_pkg::sssd_result_t res);
        logic [7:0]  b;
        logic [15:0] off;
        int          dx;
        int          dy;
        int          nib_lo;
        int          nib_hi;
        bit          has_result;
        b          = it.data_byte;
        res        = '0;
        has_result = 1'b0;
        if (it.first_byte) dec_phase = PH_MASK_HI;
        case (dec_phase)
            PH_MASK_HI: begin
                colors_left = {b, 8'h00};
                dec_phase   = PH_MASK_LO;
            end
            PH_MASK_LO: begin
                colors_left = colors_left | {8'h00, b};
                if (pick_color()) begin
                    dec_phase = PH_OFF_HI;
                end else begin
                    res         = DONE_RESULT;
                    has_result  = 1'b1;
                    colors_left = '0;
                    dec_phase   = PH_MASK_HI;
                end
            end
            PH_OFF_HI: begin
                off_hi    = b;
                dec_phase = PH_OFF_LO;
            end
            PH_OFF_LO: begin
                off       = {off_hi, b};
                dx        = int'(off) % sssd_pkg::DEF_SCREEN_PITCH;
                dy        = int'(off) / sssd_pkg::DEF_SCREEN_PITCH;
                pen_x     = sat(mirror ? org_x - dx : org_x + dx, -65536, 65535);
                pen_y     = sat(org_y + dy, -65536, 65535);
                dec_phase = PH_LEN;
            end
            PH_LEN: begin
                run_len    = int'(b) + 1;
                dec_phase  = PH_CTRL;
                res        = span_at_pen();
                has_result = 1'b1;
            end
            PH_CTRL: begin
                if (b == sssd_pkg::CTRL_NEW_OFFSET) begin
                    dec_phase = PH_OFF_HI;
                end else if (b == sssd_pkg::CTRL_END_COLOR) begin
                    colors_left[cur_color] = 1'b0;
                    if (pick_color()) begin
                        dec_phase = PH_OFF_HI;
                    end else begin
                        res         = DONE_RESULT;
                        has_result  = 1'b1;
                        colors_left = '0;
                        dec_phase   = PH_MASK_HI;
                    end
                end else begin
                    nib_lo     = $signed(b[3:0]);
                    nib_hi     = $signed(b[7:4]);
                    run_len    = sat(run_len + nib_lo - nib_hi, -1024, 1023);
                    pen_y      = sat(pen_y + 1, -65536, 65535);
                    pen_x      = sat(mirror ? pen_x - nib_hi : pen_x + nib_hi, -65536, 65535);
                    res        = span_at_pen();
                    has_result = 1'b1;
                end
            end
            default: dec_phase = PH_MASK_HI;
        endcase
        return has_result;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic first);
        stim_row_t row;
        row            = '0;
        row.item       = '{b, first};
        stim_q.push_back(row);
    endtask

    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == sssd_pkg::CTRL_NEW_OFFSET || b == sssd_pkg::CTRL_END_COLOR);
        return b;
    endfunction

    // one sprite of random shape; now and then cut short to leave the parser mid-stream
    task automatic gen_sprite();
        logic [15:0] mask;
        logic [15:0] off;
        int          start;
        int          segs;
        int          lines;
        int          cut;
        start = stim_q.size();
        case ($urandom_range(0, 9))
            0: mask = 16'h0000;
            1: mask = 16'hffff;
            2, 3, 4: mask = 16'h0001 << $urandom_range(0, 15);
            default: begin
                mask = '0;
                repeat ($urandom_range(1, 4)) mask |= 16'h0001 << $urandom_range(0, 15);
            end
        endcase
        push_byte(mask[15:8], $urandom_range(0, 4) != 0);
        push_byte(mask[7:0], 1'b0);
        for (int c = 0; c < 16; c++) begin
            if (mask[c]) begin
                segs = 1;
                while (segs < 3 && $urandom_range(0, 4) == 0) segs++;
                for (int s = 0; s < segs; s++) begin
                    if (s > 0) push_byte(sssd_pkg::CTRL_NEW_OFFSET, 1'b0);
                    case ($urandom_range(0, 5))
                        0: off = 16'h0000;
                        1: off = 16'hffff;
                        default: off = 16'($urandom);
                    endcase
                    push_byte(off[15:8], 1'b0);
                    push_byte(off[7:0], 1'b0);
                    case ($urandom_range(0, 5))
                        0: push_byte(8'h00, 1'b0);
                        1: push_byte(8'hff, 1'b0);
                        default: push_byte(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                    lines = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 8);
                    repeat (lines) push_byte(line_byte(), 1'b0);
                end
                push_byte(sssd_pkg::CTRL_END_COLOR, 1'b0);
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(start + 1, stim_q.size() - 1);
            while (stim_q.size() > cut) void'(stim_q.pop_back());
        end
    endtask

    function automatic logic [15:0] pick_origin();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic configure(input logic [15:0] x, input logic [15:0] y, input logic m);
        logic [sssd_pkg::APB_ADDR_W-1:0] addr [3];
        logic [sssd_pkg::APB_DATA_W-1:0] data [3];
        addr = '{{sssd_pkg::REG_ORIGIN_X, 2'b00}, {sssd_pkg::REG_ORIGIN_Y, 2'b00},
                 {sssd_pkg::REG_MIRRORED, 2'b00}};
        data = '{{16'h0000, x}, {16'h0000, y}, {31'd0, m}};
        for (int i = 0; i < 3; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr[i];
            pwdata  <= data[i];
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        org_x  = x;
        org_y  = y;
        mirror = m;
    endtask

    // no write goes in while a byte may still be in flight
    task automatic settle();
        while (span_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic stream_bytes(input int count);
        stim_row_t              row;
        sssd_pkg::sssd_result_t span;
        int                     burst;
        int                     gap;
        bit                     steady;
        steady = ($urandom_range(0, 3) == 0);
        burst  = 0;
        while (count > 0) begin
            row = stim_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= row.item.data_byte;
            s_tuser  <= row.item.first_byte;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            if (decode_byte(row.item, span)) span_expect_q.push_back(row.typed ? row.want : span);
            count--;
            if (burst == 0) begin
                burst = $urandom_range(1, 32);
                gap   = steady ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end else begin
                burst--;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SLOW:   m_tready <= ($urandom_range(0, 7) == 0);
            default:   m_tready <= ~m_tready;
        endcase
    end

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        sssd_pkg::sssd_result_t got;
        sssd_pkg::sssd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.span_length   = m_tdata[9:0];
            got.span_x        = m_tdata[25:10];
            got.span_y        = m_tdata[41:26];
            got.span_color    = m_tdata[45:42];
            got.right_to_left = m_tuser[0];
            got.sprite_done   = m_tuser[1];
            if (span_expect_q.size() == 0) begin
                $error("result transfer with nothing expected: m_tdata %h m_tuser %b",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = span_expect_q.pop_front();
                compare_field("span_length", want.span_length, got.span_length);
                compare_field("span_x", want.span_x, got.span_x);
                compare_field("span_y", want.span_y, got.span_y);
                compare_field("span_color", want.span_color, got.span_color);
                compare_field("right_to_left", want.right_to_left, got.right_to_left);
                compare_field("sprite_done", want.sprite_done, got.sprite_done);
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        configure(16'h0000, 16'h0000, 1'b0);

        foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);
        stream_bytes(stim_q.size());

        // mirrored at the corner of the range: x and y saturate, length clamps both ways
        settle();
        configure(16'h8000, 16'h7fff, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h08, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h2f, 1'b0);
        push_byte(8'hff, 1'b0);
        repeat (250) push_byte(8'h70, 1'b0);
        repeat (200) push_byte(8'h97, 1'b0);
        push_byte(sssd_pkg::CTRL_END_COLOR, 1'b0);
        stream_bytes(stim_q.size());

        while (stim_q.size() < RANDOM_BYTES) gen_sprite();
        while (stim_q.size() > 0) begin
            settle();
            configure(pick_origin(), pick_origin(), 1'($urandom_range(0, 1)));
            stream_bytes((stim_q.size() < 350) ? stim_q.size() : $urandom_range(150, 350));
        end

        settle();
        if (mismatch_count == 0) begin
            $display("** sprite_span_stream_decoder_core: PASSED **");
        end else begin
            $display("** sprite_span_stream_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sssd_pkg.sv
src/sssd_apb_regs.sv
src/sssd_in_stage.sv
src/sssd_parser.sv
src/sprite_span_stream_decoder_core.sv
tb/sprite_span_stream_decoder_core_tb.sv
